// ----- design/sknc_pkg.sv -----
// Shared types and constants of the skeleton node classifier.
// Used by skeleton_node_classifier; no dependencies of its own.
package sknc_pkg;

  // Default geometry and distance width
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_DIST_BITS  = 16;

  // Fixed field widths
  localparam int DIST_IN_W = 16;
  localparam int COORD_W   = 10;
  localparam int COUNT_W   = 4;
  localparam int RADIUS_W  = 16;

  // Configuration port
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int CFG_REG_W = 11;
  localparam logic [CFG_REG_W-1:0] CFG_RESET_DIM = 11'd1024;

  // Register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    NODE_ISOLATED = 2'd0,
    NODE_ENDPOINT = 2'd1,
    NODE_CORRIDOR = 2'd2,
    NODE_BRANCH   = 2'd3
  } node_class_e;

  typedef struct packed {
    logic                 skel_bit;
    logic [DIST_IN_W-1:0] dist_value;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [COUNT_W-1:0]  neighbor_count;
    node_class_e         node_class;
    logic [RADIUS_W-1:0] radius;
  } node_out_t;

endpackage

// ----- design/sknc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the line stores of skeleton_node_classifier.
module sknc_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/skeleton_node_classifier.sv -----
// Streaming 8-neighbor classifier for a raster skeleton image. Pixels enter one per clock
// unless in_stall_o holds them, in raster order, each followed per frame by width+1 flush
// items; the result for a set pixel (coordinates, in-frame neighbor count, class and
// radius) is written to the output register when the item that completes its 3x3 window,
// one row and one pixel later in the stream, leaves the stage 1 register.
// Sustained rate is one item per clock unless the clearing pass or an output stall holds
// the input, set by the read-modify-write of the line memories (two skeleton lines in one
// RAM, one distance line in another) with same-address forwarding. After reset the input
// is stalled while the skeleton line RAM is cleared; register writes are taken meanwhile.
// Depends on sknc_pkg and sknc_ram.
module skeleton_node_classifier #(
  parameter int MaxWidth  = sknc_pkg::DEF_MAX_WIDTH,
  parameter int MaxHeight = sknc_pkg::DEF_MAX_HEIGHT,
  parameter int DistBits  = sknc_pkg::DEF_DIST_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sknc_pkg::pix_in_t             in_item_i,
  // node output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sknc_pkg::node_out_t           out_item_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sknc_pkg::CFG_AW-1:0]   paddr,
  input  logic [sknc_pkg::CFG_DW-1:0]   pwdata,
  output logic [sknc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  import sknc_pkg::*;

  localparam int AW = $clog2(MaxWidth);
  localparam int CW = $clog2(MaxWidth + 1);
  localparam int HW = $clog2(MaxHeight + 1);
  localparam int RW = $clog2(MaxHeight + 3);
  localparam logic [32:0] DistMax = (33'd1 << DistBits) - 33'd1;

  // ---------------------------------------------------------------------------------
  // Registers
  logic [CFG_REG_W-1:0] cfg_width_q, cfg_height_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= CFG_RESET_DIM;
      cfg_height_q <= CFG_RESET_DIM;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  cfg_width_q  <= pwdata[CFG_REG_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_q <= pwdata[CFG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = CFG_DW'(cfg_width_q);
      REG_IMAGE_HEIGHT: prdata = CFG_DW'(cfg_height_q);
      default:          prdata = '0;
    endcase
  end

  // Clamped geometry: zero means one, above the maximum means the maximum
  logic [CW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    if (cfg_width_q == '0) begin
      w = CW'(1);
    end else if (32'(cfg_width_q) > MaxWidth) begin
      w = CW'(MaxWidth);
    end else begin
      w = CW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h = HW'(1);
    end else if (32'(cfg_height_q) > MaxHeight) begin
      h = HW'(MaxHeight);
    end else begin
      h = HW'(cfg_height_q);
    end
  end

  // ---------------------------------------------------------------------------------
  // Clearing pass of the skeleton line RAM after reset
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MaxWidth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Stream position
  logic [CW-1:0] col_q, c0, c1;
  logic [RW-1:0] row_q, r0, r1;
  logic [RW-1:0] h_ext, h_p1;
  logic          accept;

  assign h_ext = RW'(h);
  assign h_p1  = h_ext + RW'(1);

  always_comb begin
    // normalize against the current geometry
    c0 = col_q;
    r0 = row_q;
    if (c0 >= w) begin
      c0 = '0;
      r0 = r0 + RW'(1);
    end
    if (r0 > h_p1 || (r0 == h_p1 && c0 != '0)) begin
      r0 = '0;
      c0 = '0;
    end
    // advance
    c1 = c0 + CW'(1);
    r1 = r0;
    if (c1 >= w) begin
      c1 = '0;
      r1 = r0 + RW'(1);
    end
    if (r1 > h_p1 || (r1 == h_p1 && c1 != '0)) begin
      r1 = '0;
      c1 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= c1;
      row_q <= r1;
    end
  end

  // Input pixel, blanked in flush rows; distance saturated to the stored width
  logic                b_in;
  logic [32:0]         dv_ext;
  logic [DistBits-1:0] dv_in;

  assign b_in   = (r0 < h_ext) ? in_item_i.skel_bit : 1'b0;
  assign dv_ext = 33'(in_item_i.dist_value);
  assign dv_in  = (dv_ext > DistMax) ? DistMax[DistBits-1:0] : dv_ext[DistBits-1:0];

  // ---------------------------------------------------------------------------------
  // Line memories: skeleton bits {mid, top} and distance values
  logic                s1_valid_q, s1_fresh_q, s1_b_q;
  logic [CW-1:0]       s1_col_q;
  logic [RW-1:0]       s1_row_q;
  logic [DistBits-1:0] s1_dv_q;
  logic [1:0]          s1_hold_skel_q;
  logic [DistBits-1:0] s1_hold_dist_q;
  logic                s1_adv, s1_emit, s1_can_move, fwd;

  logic                skel_we;
  logic [AW-1:0]       skel_waddr;
  logic [1:0]          skel_wdata, skel_rdata, skel_eff;
  logic [DistBits-1:0] dist_rdata, dist_eff;
  logic                top_eff, mid_eff;

  assign skel_we    = clr_busy_q || s1_adv;
  assign skel_waddr = clr_busy_q ? clr_addr_q : s1_col_q[AW-1:0];
  assign skel_wdata = clr_busy_q ? 2'b00 : {s1_b_q, mid_eff};

  sknc_ram #(
    .Width (2),
    .Depth (MaxWidth)
  ) u_skel_ram (
    .clk_i   (clk_i),
    .we_i    (skel_we),
    .waddr_i (skel_waddr),
    .wdata_i (skel_wdata),
    .re_i    (accept),
    .raddr_i (c0[AW-1:0]),
    .rdata_o (skel_rdata)
  );

  sknc_ram #(
    .Width (DistBits),
    .Depth (MaxWidth)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q[AW-1:0]),
    .wdata_i (s1_dv_q),
    .re_i    (accept),
    .raddr_i (c0[AW-1:0]),
    .rdata_o (dist_rdata)
  );

  // Read data: live from the RAM, or held / forwarded
  assign skel_eff = s1_fresh_q ? skel_rdata : s1_hold_skel_q;
  assign dist_eff = s1_fresh_q ? dist_rdata : s1_hold_dist_q;
  assign top_eff  = skel_eff[0];
  assign mid_eff  = skel_eff[1];

  // ---------------------------------------------------------------------------------
  // Handshake and flow
  logic out_valid_q;

  assign s1_can_move = !s1_emit || !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && s1_can_move;
  assign in_stall_o  = clr_busy_q || (s1_valid_q && !s1_can_move);
  assign accept      = in_valid_i && !in_stall_o;
  // the item leaving stage 1 writes the entry this item reads in the same cycle
  assign fwd         = s1_adv && (s1_col_q == c0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fresh_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_fresh_q <= !fwd;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && !s1_adv) begin
        s1_fresh_q <= 1'b0;
      end
    end
  end

  // Stage 1 payload and read-data hold
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q       <= c0;
      s1_row_q       <= r0;
      s1_b_q         <= b_in;
      s1_dv_q        <= dv_in;
      s1_hold_skel_q <= {s1_b_q, mid_eff};
      s1_hold_dist_q <= s1_dv_q;
    end else if (s1_valid_q && s1_fresh_q && !s1_adv) begin
      s1_hold_skel_q <= skel_rdata;
      s1_hold_dist_q <= dist_rdata;
    end
  end

  // ---------------------------------------------------------------------------------
  // Window, centre position and classification
  logic [8:0]          win_q, win_n, win_m;
  logic [DistBits-1:0] dist_hold_q;
  logic [CW-1:0]       cc;
  logic [RW-1:0]       cr;
  logic                pos_ok;
  logic [COUNT_W-1:0]  n_cnt;
  node_class_e         n_class;
  logic [32:0]         cd_ext;
  logic [RADIUS_W-1:0] radius;

  assign win_n = {s1_b_q, mid_eff, top_eff, win_q[8:3]};

  always_comb begin
    if (s1_col_q != '0) begin
      cc     = s1_col_q - CW'(1);
      cr     = s1_row_q - RW'(1);
      pos_ok = (s1_row_q >= RW'(1)) && (s1_row_q <= h_ext);
    end else begin
      cc     = w - CW'(1);
      cr     = s1_row_q - RW'(2);
      pos_ok = (s1_row_q >= RW'(2)) && (s1_row_q <= h_p1);
    end
  end

  assign s1_emit = pos_ok && win_q[7];

  // Mask the centre and neighbors outside the frame, then count
  always_comb begin
    win_m    = win_n;
    win_m[4] = 1'b0;
    if (cc == '0) begin
      win_m[2:0] = 3'b000;
    end
    if (cc == w - CW'(1)) begin
      win_m[8:6] = 3'b000;
    end
    if (cr == '0) begin
      win_m[0] = 1'b0;
      win_m[3] = 1'b0;
      win_m[6] = 1'b0;
    end
    if (cr == h_ext - RW'(1)) begin
      win_m[2] = 1'b0;
      win_m[5] = 1'b0;
      win_m[8] = 1'b0;
    end
    n_cnt = '0;
    for (int i = 0; i < 9; i++) begin
      n_cnt = n_cnt + COUNT_W'(win_m[i]);
    end
    case (n_cnt)
      4'd0:    n_class = NODE_ISOLATED;
      4'd1:    n_class = NODE_ENDPOINT;
      4'd2:    n_class = NODE_CORRIDOR;
      default: n_class = NODE_BRANCH;
    endcase
  end

  assign cd_ext = 33'(dist_hold_q);
  assign radius = (cd_ext > 33'h0FFFF) ? {RADIUS_W{1'b1}} : cd_ext[RADIUS_W-1:0];

  // Window state advances once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_n;
    end
  end

  // Distance of the centre trails the line by one item
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      dist_hold_q <= dist_eff;
    end
  end

  // ---------------------------------------------------------------------------------
  // Output register
  node_out_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      out_item_q.col            <= COORD_W'(cc);
      out_item_q.row            <= COORD_W'(cr);
      out_item_q.neighbor_count <= n_cnt;
      out_item_q.node_class     <= n_class;
      out_item_q.radius         <= radius;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- test/sknc_node_checker.sv -----
// Checker for the skeleton node classifier: tracks register writes, predicts the node
// item due for every accepted pixel and compares results as they leave the block.
// Depends on sknc_pkg for the item types, class codes and register indexes.
module sknc_node_checker #(
  parameter int MaxWidth  = sknc_pkg::DEF_MAX_WIDTH,
  parameter int MaxHeight = sknc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  sknc_pkg::pix_in_t           in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  sknc_pkg::node_out_t         out_item_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [sknc_pkg::CFG_AW-1:0] paddr_i,
  input  logic [sknc_pkg::CFG_DW-1:0] pwdata_i,
  input  logic [sknc_pkg::CFG_DW-1:0] prdata_i,
  input  logic                        pready_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sknc_pkg::*;

  // Shadow registers and line stores
  logic [CFG_REG_W-1:0] width_reg, height_reg, reg_seen;
  logic                 skel_prev [MaxWidth];
  logic                 skel_mid  [MaxWidth];
  logic [DIST_IN_W-1:0] dist_line [MaxWidth];
  logic [DIST_IN_W-1:0] dist_hold;
  logic [8:0]           win3x3;
  int unsigned          col_pos, row_pos;
  node_out_t            expected_nodes [$];
  node_out_t            want;
  int                   fails, checked;

  function automatic int unsigned clamp_dim(logic [CFG_REG_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: node %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  // Advance the pixel stream by one item and queue the node it completes, if any
  task automatic predict_node(input pix_in_t px);
    int unsigned w, h, c, r, cc, n;
    int          cr;
    logic        b, top, mid;
    logic [8:0]  m;
    logic [DIST_IN_W-1:0] cd;
    node_out_t   nd;
    w = clamp_dim(width_reg, MaxWidth);
    h = clamp_dim(height_reg, MaxHeight);
    // re-align the position after a geometry change
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1 || (row_pos == h + 1 && col_pos != 0)) begin
      row_pos = 0;
      col_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    b = (r < h) ? px.skel_bit : 1'b0;
    // column of rows r-2, r-1, r shifts into the window
    top = skel_prev[c];
    mid = skel_mid[c];
    skel_prev[c] = mid;
    skel_mid[c]  = b;
    win3x3 = {b, mid, top, win3x3[8:3]};
    cd = dist_hold;
    dist_hold = dist_line[c];
    dist_line[c] = px.dist_value;
    if (c >= 1) begin
      cc = c - 1;
      cr = int'(r) - 1;
    end else begin
      cc = w - 1;
      cr = int'(r) - 2;
    end
    if (cr >= 0 && cr < int'(h) && win3x3[4]) begin
      m = win3x3;
      m[4] = 1'b0;
      // neighbors outside the frame count as zero
      if (cc == 0) m[2:0] = 3'b000;
      if (cc + 1 >= w) m[8:6] = 3'b000;
      if (cr == 0) m = m & ~9'h049;
      if (cr + 1 >= int'(h)) m = m & ~9'h124;
      n = $countones(m);
      nd.col = cc[COORD_W-1:0];
      nd.row = cr[COORD_W-1:0];
      nd.neighbor_count = n[COUNT_W-1:0];
      case (n)
        0: nd.node_class = NODE_ISOLATED;
        1: nd.node_class = NODE_ENDPOINT;
        2: nd.node_class = NODE_CORRIDOR;
        default: nd.node_class = NODE_BRANCH;
      endcase
      nd.radius = cd;
      expected_nodes = {expected_nodes, nd};
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r > h + 1 || (r == h + 1 && c != 0)) begin
      r = 0;
      c = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Watch register port and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = CFG_RESET_DIM;
      height_reg = CFG_RESET_DIM;
      for (int i = 0; i < MaxWidth; i++) begin
        skel_prev[i] = 1'b0;
        skel_mid[i]  = 1'b0;
        dist_line[i] = '0;
      end
      dist_hold = '0;
      win3x3    = '0;
      col_pos   = 0;
      row_pos   = 0;
      expected_nodes.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_IMAGE_WIDTH) width_reg = pwdata_i[CFG_REG_W-1:0];
          else height_reg = pwdata_i[CFG_REG_W-1:0];
        end else begin
          reg_seen = (paddr_i[2] == REG_IMAGE_WIDTH) ? width_reg : height_reg;
          if (prdata_i[CFG_REG_W-1:0] !== reg_seen) begin
            $display("%0t ns: register read mismatch at %0d, expected %0d, actual %0d",
                     $time, paddr_i, reg_seen, prdata_i[CFG_REG_W-1:0]);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_node(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_nodes.size() == 0) begin
          $display("%0t ns: unexpected node item, expected none, actual col %0d row %0d",
                   $time, out_item_i.col, out_item_i.row);
          fails++;
        end else begin
          want = expected_nodes.pop_front();
          check_field("col", want.col, out_item_i.col);
          check_field("row", want.row, out_item_i.row);
          check_field("neighbor_count", want.neighbor_count, out_item_i.neighbor_count);
          check_field("node_class", want.node_class, out_item_i.node_class);
          check_field("radius", want.radius, out_item_i.radius);
          checked++;
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_nodes.size();
    checked_o    <= checked;
  end

endmodule

// ----- test/testbench.sv -----
// Top of the skeleton node classifier test: clock, reset, register writes, pixel
// stimulus with input gaps and output stalls, and the final verdict.
// Depends on sknc_pkg, skeleton_node_classifier and sknc_node_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sknc_pkg::*;

  localparam int          RANDOM_ITEMS   = 450;
  localparam int          WIDE_ITEMS     = 1100;
  localparam int          TALL_ITEMS     = 200;
  localparam int          DRAIN_CYCLES   = 8;
  // 5x4 frame holding isolated, endpoint, corridor and branch pixels, one with 8 neighbors
  localparam logic [19:0] DIRECTED_FRAME = 20'hC1CF7;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  pix_in_t             in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  node_out_t           out_item;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [CFG_AW-1:0]   paddr     = '0;
  logic [CFG_DW-1:0]   pwdata    = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  int                  fail_count, pending, checked;
  int unsigned         send_idle_pct  = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         cur_w, cur_h, items_sent, settings_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  skeleton_node_classifier dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  sknc_node_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Output backpressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic set_mode(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  // Register access: setup cycle, then access until pready
  task automatic reg_access(input logic wr, input logic idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every expected node has left, then let the pipeline drain
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h);
    wait_idle();
    reg_access(1'b1, REG_IMAGE_WIDTH, w);
    reg_access(1'b1, REG_IMAGE_HEIGHT, h);
    reg_access(1'b0, REG_IMAGE_WIDTH, '0);
    reg_access(1'b0, REG_IMAGE_HEIGHT, '0);
    cur_w = (w[CFG_REG_W-1:0] == 0) ? 1 : (w[CFG_REG_W-1:0] > DEF_MAX_WIDTH) ?
            DEF_MAX_WIDTH : w[CFG_REG_W-1:0];
    cur_h = (h[CFG_REG_W-1:0] == 0) ? 1 : (h[CFG_REG_W-1:0] > DEF_MAX_HEIGHT) ?
            DEF_MAX_HEIGHT : h[CFG_REG_W-1:0];
    settings_count++;
  endtask

  // One pixel item, with random gaps ahead of it
  task automatic send_pixel(input logic b, input logic [DIST_IN_W-1:0] d);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= pix_in_t'{skel_bit: b, dist_value: d};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_items(input int unsigned cnt, input int unsigned dens);
    logic [DIST_IN_W-1:0] d;
    for (int unsigned i = 0; i < cnt; i++) begin
      case ($urandom_range(7))
        0: d = '0;
        1: d = '1;
        default: d = DIST_IN_W'($urandom);
      endcase
      send_pixel($urandom_range(99) < dens, d);
    end
    in_valid <= 1'b0;
  endtask

  // Full frames including the flush items that follow each
  function automatic int unsigned frame_items();
    return (cur_h + 1) * cur_w + 1;
  endfunction

  initial begin
    int unsigned random_sent, phase, w, h, dens;
    logic [DIST_IN_W-1:0] d;
    random_sent = 0;
    phase = 0;
    items_sent = 0;
    settings_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frame with its flush items, values at both extremes
    set_mode(0);
    set_geometry(5, 4);
    for (int unsigned k = 0; k < frame_items(); k++) begin
      case (k % 3)
        0: d = '0;
        1: d = '1;
        default: d = DIST_IN_W'($urandom);
      endcase
      send_pixel((k < 20) ? DIRECTED_FRAME[k] : 1'b1, d);
    end
    in_valid <= 1'b0;

    // Geometry extremes, out-of-range values clamped; the wide frame runs past the
    // full line, the single-column one is cut off early
    set_mode(1);
    set_geometry(2047, 0);
    send_items(WIDE_ITEMS, 50);
    set_mode(2);
    set_geometry(0, 2047);
    send_items(TALL_ITEMS, 60);

    // Random geometries, mostly whole frames, some cut off mid-frame
    while (random_sent < RANDOM_ITEMS) begin
      set_mode(phase);
      w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 16);
      h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
      dens = $urandom_range(1, 9) * 10;
      set_geometry(w, h);
      if ($urandom_range(4) == 0) w = $urandom_range(1, 2 * frame_items());
      else w = $urandom_range(1, 3) * frame_items();
      send_items(w, dens);
      random_sent += w;
      phase++;
    end

    wait_idle();
    $display("Checked %0d node items from %0d pixel items over %0d geometry settings,",
             checked, items_sent, settings_count);
    $display("with input gaps, output stalls and geometry changes inside a frame.");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Run limit reached with %0d node items outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
